[rtl/core/goertzel_tone_magnitude_macros.svh]
// assertion helpers for the tone magnitude block
`ifndef GOERTZEL_TONE_MAGNITUDE_MACROS_SVH
`define GOERTZEL_TONE_MAGNITUDE_MACROS_SVH
`ifndef SYNTHESIS
`define GTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtm check failed");
`define GTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtm check failed");
`else
`define GTM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/gtm_pkg.sv]
package gtm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 19;
  localparam int COEF_FRAC  = 16;
  localparam int STATE_W    = 56;
  localparam int STATE_FRAC = 16;
  localparam int MAX_BLOCK  = 4096;
  localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
  localparam int OUT_W      = 16;

  // recursion datapath
  localparam int HALF_W = STATE_W / 2;
  localparam int PLO_W  = COEF_W + HALF_W + 1;
  localparam int PHI_W  = COEF_W + STATE_W - HALF_W;
  localparam int PROD_W = COEF_W + STATE_W + 1;
  localparam int T1_W   = PROD_W - COEF_FRAC;
  localparam int SUM_W  = T1_W + 2;

  // finishing datapath
  localparam int OP_W   = STATE_W + COEF_W - COEF_FRAC;
  localparam int MAG_W  = OP_W - 1;
  localparam int LIMB_W = MAG_W / 2;
  localparam int PP_W   = 2 * LIMB_W;
  localparam int ACC_W  = 2 * MAG_W + 2;
  localparam int RAD_W  = 2 * STATE_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int QUO_W  = ROOT_W - STATE_FRAC;
  localparam int STEP_W = $clog2(ROOT_W);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [STATE_W-1:0] s1;
    logic signed [STATE_W-1:0] s2;
    logic [CNT_W-1:0]          cnt;
    logic                      clip;
    logic signed [COEF_W-1:0]  coef;
  } gtm_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gtm_qstat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADD,
    F_UPD
  } gtm_fstate_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_FLUSH_T,
    B_TSAVE,
    B_FLUSH_M,
    B_CHECK,
    B_SQRT,
    B_DIV,
    B_DONE
  } gtm_bstate_t;

endpackage

[rtl/core/gtm_front.sv]
module gtm_front import gtm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  input  logic signed [COEF_W-1:0]   coef,
  input  gtm_qstat_t                 q_stat,
  output logic                       q_push,
  output gtm_entry_t                 q_data
);

  localparam logic signed [STATE_W-1:0] S_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] S_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  gtm_fstate_t                state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic                       last_r, last_nxt;
  logic signed [PLO_W-1:0]    plo_r, plo_nxt;
  logic signed [PHI_W-1:0]    phi_r, phi_nxt;
  logic signed [T1_W-1:0]     t1_r, t1_nxt;
  logic signed [STATE_W-1:0]  s1_r, s1_nxt;
  logic signed [STATE_W-1:0]  s2_r, s2_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       clip_r, clip_nxt;

  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    sum;
  logic signed [STATE_W-1:0]  s0;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       over, under, clip_now, done_ok, take;

  assign prod    = (PROD_W'(phi_r) <<< HALF_W) + PROD_W'(plo_r);
  assign sum     = (SUM_W'(x_r) <<< STATE_FRAC) + SUM_W'(t1_r) - SUM_W'(s2_r);
  assign over    = sum > SUM_W'(S_MAX);
  assign under   = sum < SUM_W'(S_MIN);
  assign clip_now = over || under;
  assign s0      = over ? S_MAX : (under ? S_MIN : sum[STATE_W-1:0]);
  assign cnt_inc = (cnt_r < CNT_W'(MAX_BLOCK)) ? CNT_W'(cnt_r + 1'b1) : cnt_r;
  assign done_ok = !last_r || !q_stat.full;

  assign q_data.s1   = s0;
  assign q_data.s2   = s1_r;
  assign q_data.cnt  = cnt_inc;
  assign q_data.clip = clip_r | clip_now;
  assign q_data.coef = coef;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      s1_r    <= '0;
      s2_r    <= '0;
      cnt_r   <= '0;
      clip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      cnt_r   <= cnt_nxt;
      clip_r  <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    last_r <= last_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    t1_r   <= t1_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    last_nxt  = last_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    t1_nxt    = t1_r;
    s1_nxt    = s1_r;
    s2_nxt    = s2_r;
    cnt_nxt   = cnt_r;
    clip_nxt  = clip_r;
    full      = 1'b1;
    q_push    = 1'b0;
    take      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        full = 1'b0;
        take = push;
      end
      F_MUL: begin
        plo_nxt   = coef * $signed({1'b0, s1_r[HALF_W-1:0]});
        phi_nxt   = coef * $signed(s1_r[STATE_W-1:HALF_W]);
        state_nxt = F_ADD;
      end
      F_ADD: begin
        t1_nxt    = T1_W'(prod >>> COEF_FRAC);
        state_nxt = F_UPD;
      end
      F_UPD: begin
        if (done_ok) begin
          full      = 1'b0;
          take      = push;
          state_nxt = F_IDLE;
          if (last_r) begin
            q_push   = 1'b1;
            s1_nxt   = '0;
            s2_nxt   = '0;
            cnt_nxt  = '0;
            clip_nxt = 1'b0;
          end else begin
            s1_nxt   = s0;
            s2_nxt   = s1_r;
            cnt_nxt  = cnt_inc;
            clip_nxt = clip_r | clip_now;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
    if (take) begin
      x_nxt     = sample;
      last_nxt  = last;
      state_nxt = F_MUL;
    end
  end

endmodule

[rtl/core/gtm_fifo.sv]
module gtm_fifo import gtm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gtm_entry_t wr_data,
  input  logic       pop,
  output gtm_entry_t rd_data,
  output gtm_qstat_t stat
);

  gtm_entry_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = cnt_r == FIFO_CW'(FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? FIFO_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = FIFO_CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = FIFO_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/core/gtm_back.sv]
module gtm_back import gtm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  gtm_qstat_t        q_stat,
  input  gtm_entry_t        q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [OUT_W-1:0]  magnitude,
  output logic              saturated
);

  localparam logic [1:0] TERM_CS2  = 2'd0;
  localparam logic [1:0] TERM_S1S1 = 2'd1;
  localparam logic [1:0] TERM_S2S2 = 2'd2;
  localparam logic [1:0] TERM_S1T  = 2'd3;

  gtm_bstate_t               state_r, state_nxt;
  logic signed [STATE_W-1:0] s1_r, s1_nxt;
  logic signed [STATE_W-1:0] s2_r, s2_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      clip_r, clip_nxt;
  logic signed [COEF_W-1:0]  coef_r, coef_nxt;
  logic [1:0]                term_r, term_nxt;
  logic [1:0]                lstep_r, lstep_nxt;
  logic [PP_W-1:0]           pp_r, pp_nxt;
  logic [1:0]                pp_sh_r, pp_sh_nxt;
  logic                      pp_neg_r, pp_neg_nxt;
  logic                      pp_vld_r, pp_vld_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [OP_W-1:0]    t_r, t_nxt;
  logic [RAD_W-1:0]          rad_r, rad_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [QUO_W-1:0]          quo_r, quo_nxt;
  logic [CNT_W-1:0]          drem_r, drem_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      res_vld_r, res_vld_nxt;
  logic [OUT_W-1:0]          res_mag_r, res_mag_nxt;
  logic                      res_sat_r, res_sat_nxt;

  logic signed [OP_W-1:0]    op_a, op_b;
  logic [MAG_W-1:0]          mag_a, mag_b;
  logic [LIMB_W-1:0]         limb_a, limb_b;
  logic signed [ACC_W-1:0]   addend, acc_add, acc_sh;
  logic [REM_W+1:0]          sq_in, sq_trial, sq_diff;
  logic                      sq_ge;
  logic [CNT_W:0]            dv_in, dv_div, dv_diff;
  logic                      dv_ge, quo_over;

  // operand pairs of the four products
  always_comb begin
    op_a = OP_W'(s1_r);
    op_b = OP_W'(s1_r);
    case (term_r)
      TERM_CS2: begin
        op_a = OP_W'(coef_r);
        op_b = OP_W'(s2_r);
      end
      TERM_S1S1: begin
        op_a = OP_W'(s1_r);
        op_b = OP_W'(s1_r);
      end
      TERM_S2S2: begin
        op_a = OP_W'(s2_r);
        op_b = OP_W'(s2_r);
      end
      TERM_S1T: begin
        op_a = OP_W'(s1_r);
        op_b = t_r;
      end
      default: begin
        op_a = OP_W'(s1_r);
        op_b = t_r;
      end
    endcase
  end

  assign mag_a  = op_a[OP_W-1] ? MAG_W'(-op_a) : MAG_W'(op_a);
  assign mag_b  = op_b[OP_W-1] ? MAG_W'(-op_b) : MAG_W'(op_b);
  assign limb_a = lstep_r[1] ? mag_a[MAG_W-1:LIMB_W] : mag_a[LIMB_W-1:0];
  assign limb_b = lstep_r[0] ? mag_b[MAG_W-1:LIMB_W] : mag_b[LIMB_W-1:0];

  always_comb begin
    case (pp_sh_r)
      2'd0:    addend = ACC_W'(pp_r);
      2'd1:    addend = ACC_W'(pp_r) << LIMB_W;
      default: addend = ACC_W'(pp_r) << (2 * LIMB_W);
    endcase
  end

  assign acc_add = pp_neg_r ? acc_r - addend : acc_r + addend;
  assign acc_sh  = acc_r >>> COEF_FRAC;

  // one root bit per step
  assign sq_in    = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign sq_trial = (REM_W + 2)'({root_r, 2'b01});
  assign sq_ge    = sq_in >= sq_trial;
  assign sq_diff  = sq_in - sq_trial;

  // one quotient bit per step
  assign dv_in   = {drem_r, quo_r[QUO_W-1]};
  assign dv_div  = {1'b0, cnt_r};
  assign dv_ge   = dv_in >= dv_div;
  assign dv_diff = dv_in - dv_div;

  assign quo_over = |quo_r[QUO_W-1:OUT_W];

  assign empty     = !res_vld_r;
  assign magnitude = res_mag_r;
  assign saturated = res_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      pp_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pp_vld_r  <= pp_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r      <= s1_nxt;
    s2_r      <= s2_nxt;
    cnt_r     <= cnt_nxt;
    clip_r    <= clip_nxt;
    coef_r    <= coef_nxt;
    term_r    <= term_nxt;
    lstep_r   <= lstep_nxt;
    pp_r      <= pp_nxt;
    pp_sh_r   <= pp_sh_nxt;
    pp_neg_r  <= pp_neg_nxt;
    acc_r     <= acc_nxt;
    t_r       <= t_nxt;
    rad_r     <= rad_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    quo_r     <= quo_nxt;
    drem_r    <= drem_nxt;
    step_r    <= step_nxt;
    res_mag_r <= res_mag_nxt;
    res_sat_r <= res_sat_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    s1_nxt      = s1_r;
    s2_nxt      = s2_r;
    cnt_nxt     = cnt_r;
    clip_nxt    = clip_r;
    coef_nxt    = coef_r;
    term_nxt    = term_r;
    lstep_nxt   = lstep_r;
    pp_nxt      = limb_a * limb_b;
    pp_sh_nxt   = {1'b0, lstep_r[1]} + {1'b0, lstep_r[0]};
    pp_neg_nxt  = op_a[OP_W-1] ^ op_b[OP_W-1] ^ (term_r == TERM_S1T);
    pp_vld_nxt  = 1'b0;
    acc_nxt     = pp_vld_r ? acc_add : acc_r;
    t_nxt       = t_r;
    rad_nxt     = rad_r;
    rem_nxt     = rem_r;
    root_nxt    = root_r;
    quo_nxt     = quo_r;
    drem_nxt    = drem_r;
    step_nxt    = step_r;
    res_vld_nxt = res_vld_r && !pop;
    res_mag_nxt = res_mag_r;
    res_sat_nxt = res_sat_r;
    q_pop       = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          s1_nxt    = q_data.s1;
          s2_nxt    = q_data.s2;
          cnt_nxt   = q_data.cnt;
          clip_nxt  = q_data.clip;
          coef_nxt  = q_data.coef;
          acc_nxt   = '0;
          term_nxt  = TERM_CS2;
          lstep_nxt = '0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        pp_vld_nxt = 1'b1;
        lstep_nxt  = lstep_r + 1'b1;
        if (&lstep_r) begin
          if (term_r == TERM_CS2) begin
            term_nxt  = TERM_S1S1;
            state_nxt = B_FLUSH_T;
          end else if (term_r == TERM_S1T) begin
            state_nxt = B_FLUSH_M;
          end else begin
            term_nxt = term_r + 1'b1;
          end
        end
      end
      B_FLUSH_T: state_nxt = B_TSAVE;
      B_TSAVE: begin
        t_nxt     = acc_sh[OP_W-1:0];
        acc_nxt   = '0;
        state_nxt = B_MUL;
      end
      B_FLUSH_M: state_nxt = B_CHECK;
      B_CHECK: begin
        if (!acc_r[ACC_W-1] && (acc_r != '0)) begin
          rad_nxt   = acc_r[RAD_W-1:0];
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = B_SQRT;
        end else begin
          quo_nxt   = '0;
          state_nxt = B_DONE;
        end
      end
      B_SQRT: begin
        rad_nxt  = rad_r << 2;
        rem_nxt  = sq_ge ? sq_diff[REM_W-1:0] : sq_in[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], sq_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          quo_nxt   = root_nxt[ROOT_W-1:STATE_FRAC];
          drem_nxt  = '0;
          step_nxt  = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        drem_nxt = dv_ge ? dv_diff[CNT_W-1:0] : dv_in[CNT_W-1:0];
        quo_nxt  = {quo_r[QUO_W-2:0], dv_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!res_vld_r) begin
          res_vld_nxt = 1'b1;
          res_mag_nxt = quo_over ? {OUT_W{1'b1}} : quo_r[OUT_W-1:0];
          res_sat_nxt = clip_r | quo_over;
          state_nxt   = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

endmodule

[rtl/core/goertzel_tone_magnitude.sv]
// channel   direction  handshake            word
// samples   in         push / full          in_sample, in_last
// results   out        pop / empty          out_magnitude, out_saturated
// config    in         cfg_valid / cfg_ready cfg_coefficient
//
// the recursion steps each sample through multiply, add and update states,
// and takes the next sample in the update state unless a last sample waits on a full queue
// per block the back end forms the four products limb by limb, then takes 57 root steps
// and 41 divide steps, while the front end runs on
// full is high during the recursion and at a last sample while the block queue is full
// reset is synchronous and clears the coefficient, the state and the queues
`include "goertzel_tone_magnitude_macros.svh"
module goertzel_tone_magnitude import gtm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       empty,
  input  logic                       pop,
  output logic [OUT_W-1:0]           out_magnitude,
  output logic                       out_saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic signed [COEF_W-1:0]   cfg_coefficient
);

  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  gtm_qstat_t               q_stat;
  gtm_entry_t               q_wr, q_rd;
  logic                     q_push, q_pop;

  assign cfg_ready = 1'b1;
  assign coef_nxt  = (cfg_valid && cfg_ready) ? cfg_coefficient : coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  gtm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .sample (in_sample),
    .last   (in_last),
    .coef   (coef_r),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wr)
  );

  gtm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  gtm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_rd),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .magnitude (out_magnitude),
    .saturated (out_saturated)
  );

  `GTM_ASSERT_SAME(a_queue_no_overflow, clk, rst_n, q_stat.full, !q_push)
  `GTM_ASSERT_SAME(a_queue_no_underflow, clk, rst_n, q_stat.empty, !q_pop)
  `GTM_ASSERT_NEXT(a_queue_holds_block, clk, rst_n, q_push && !q_stat.full, !q_stat.empty)

endmodule
